// ===== rtl/stereo_three_band_biquad_eq_defines.svh =====
// ----------------------------------------------------------------------------
// Stereo three-band equalizer assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef STEREO_THREE_BAND_BIQUAD_EQ_DEFINES_SVH
`define STEREO_THREE_BAND_BIQUAD_EQ_DEFINES_SVH

`ifndef SYNTHESIS
`define STEQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);
`define STEQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define STEQ_ASSERT(name, prop, msg)
`define STEQ_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== rtl/steq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo three-band equalizer package
// Widths, codes and the control bundle shared by the sequencer and lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package steq_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int COEFF_FRAC_BITS = 16;
	localparam int COEFF_BITS      = 21;
	localparam int NUM_BANDS       = 3;
	localparam int FF_BITS         = 3 * COEFF_BITS;
	localparam int FB_BITS         = 2 * COEFF_BITS;
	localparam int PROD_BITS       = SAMPLE_BITS + COEFF_BITS;
	localparam int ACC_BITS        = PROD_BITS + 3;
	localparam int CFG_IDX_BITS    = 3;

	localparam logic [FF_BITS-1:0] FF_RESET = FF_BITS'(1) << COEFF_FRAC_BITS;
	localparam logic signed [ACC_BITS-1:0] ROUND_CONST =
		ACC_BITS'(1) << (COEFF_FRAC_BITS - 1);
	localparam logic signed [ACC_BITS-1:0] SAT_HI =
		(ACC_BITS'(1) << (SAMPLE_BITS - 1)) - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEFF_BITS-1:0]  coeff_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LOW_FF,
		REG_LOW_FB,
		REG_MID_FF,
		REG_MID_FB,
		REG_HIGH_FF,
		REG_HIGH_FB
	} reg_idx_t;

	typedef enum logic [1:0] {
		BAND_LOW,
		BAND_MID,
		BAND_HIGH
	} band_t;

	// x, x[n-1], x[n-2], y[n-1], y[n-2]
	typedef enum logic [2:0] {
		TAP_X0,
		TAP_X1,
		TAP_X2,
		TAP_Y1,
		TAP_Y2
	} tap_t;

	typedef struct packed {
		logic  load;
		logic  mac;
		logic  first;
		logic  sub;
		logic  wb;
		band_t band;
		tap_t  tap;
	} lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/steq_if.sv =====
// ----------------------------------------------------------------------------
// Stereo three-band equalizer channel interfaces
// Frame input, frame output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface steq_in_if
	import steq_pkg::*;
	;
	logic    valid;
	logic    ready;
	sample_t left_in;
	sample_t right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface steq_out_if
	import steq_pkg::*;
	;
	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface steq_cfg_if
	import steq_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [FF_BITS-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/stereo_three_band_biquad_eq.sv =====
// ----------------------------------------------------------------------------
// Stereo three-band biquad equalizer
// Low shelf, peaking and high shelf sections in cascade on each channel.
//
// frame_in carries one stereo frame per item; frame_out returns the equalized
// frame, one item for each input item, in order. cfg writes the six
// coefficient registers (index 0..5, others ignored); it is always ready and
// should only be used while no frame is in flight.
// Two lanes, one per channel, each with one 24x21 multiplier, run in
// lockstep. Each band runs a multiply-accumulate step for each tap, then
// a drain step and a writeback step; after the high band the result is
// handed to the output register, which raises frame_out valid. A new frame
// is accepted only in the idle state, once the previous one has been handed
// to the output register.
// A new frame can be taken while the previous result waits in the
// output register; the lanes then hold their result until it is free.
// Reset clears all filter history and loads unity-gain coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_three_band_biquad_eq_defines.svh"

module stereo_three_band_biquad_eq
	import steq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	steq_in_if.sink    frame_in,
	steq_out_if.source frame_out,
	steq_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_WB,
		ST_DONE
	} state_t;

	state_t state_q;
	band_t  band_q;
	tap_t   tap_q;

	logic [FF_BITS-1:0] ff_q [NUM_BANDS];
	logic [FB_BITS-1:0] fb_q [NUM_BANDS];
	logic [FF_BITS-1:0] ff_sel;
	logic [FB_BITS-1:0] fb_sel;
	coeff_t             coeff;

	lane_ctrl_t ctrl;
	logic       accept;
	logic       out_full;
	logic       out_load;
	sample_t    left_res;
	sample_t    right_res;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANDS; b++) begin
				ff_q[b] <= FF_RESET;
				fb_q[b] <= '0;
			end
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LOW_FF:  ff_q[BAND_LOW]  <= cfg.data;
				REG_LOW_FB:  fb_q[BAND_LOW]  <= cfg.data[FB_BITS-1:0];
				REG_MID_FF:  ff_q[BAND_MID]  <= cfg.data;
				REG_MID_FB:  fb_q[BAND_MID]  <= cfg.data[FB_BITS-1:0];
				REG_HIGH_FF: ff_q[BAND_HIGH] <= cfg.data;
				REG_HIGH_FB: fb_q[BAND_HIGH] <= cfg.data[FB_BITS-1:0];
				default: ;
			endcase
		end
	end

	// coefficient shared by both lanes
	always_comb begin
		unique case (band_q)
			BAND_LOW: begin
				ff_sel = ff_q[BAND_LOW];
				fb_sel = fb_q[BAND_LOW];
			end
			BAND_MID: begin
				ff_sel = ff_q[BAND_MID];
				fb_sel = fb_q[BAND_MID];
			end
			BAND_HIGH: begin
				ff_sel = ff_q[BAND_HIGH];
				fb_sel = fb_q[BAND_HIGH];
			end
			default: begin
				ff_sel = '0;
				fb_sel = '0;
			end
		endcase
		case (tap_q)
			TAP_X0:  coeff = ff_sel[COEFF_BITS-1:0];
			TAP_X1:  coeff = ff_sel[2*COEFF_BITS-1:COEFF_BITS];
			TAP_X2:  coeff = ff_sel[3*COEFF_BITS-1:2*COEFF_BITS];
			TAP_Y1:  coeff = fb_sel[COEFF_BITS-1:0];
			TAP_Y2:  coeff = fb_sel[2*COEFF_BITS-1:COEFF_BITS];
			default: coeff = '0;
		endcase
	end

	// sequencer
	assign frame_in.ready = (state_q == ST_IDLE);
	assign accept         = frame_in.valid && frame_in.ready;
	assign out_load       = (state_q == ST_DONE) && (!out_full || frame_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			band_q  <= BAND_LOW;
			tap_q   <= TAP_X0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAC;
						band_q  <= BAND_LOW;
						tap_q   <= TAP_X0;
					end
				end
				ST_MAC: begin
					if (tap_q == TAP_Y2) begin
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_t'(tap_q + 3'd1);
					end
				end
				ST_DRAIN: state_q <= ST_WB;
				ST_WB: begin
					tap_q <= TAP_X0;
					if (band_q == BAND_HIGH) begin
						state_q <= ST_DONE;
					end else begin
						band_q  <= band_t'(band_q + 2'd1);
						state_q <= ST_MAC;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						band_q  <= BAND_LOW;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctrl.load  = accept;
		ctrl.mac   = (state_q == ST_MAC);
		ctrl.first = (tap_q == TAP_X0);
		ctrl.sub   = (tap_q == TAP_Y1) || (tap_q == TAP_Y2);
		ctrl.wb    = (state_q == ST_WB);
		ctrl.band  = band_q;
		ctrl.tap   = tap_q;
	end

	steq_lane u_lane_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample_in (frame_in.left_in),
		.coeff     (coeff),
		.result    (left_res)
	);

	steq_lane u_lane_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample_in (frame_in.right_in),
		.coeff     (coeff),
		.result    (right_res)
	);

	steq_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.left_res  (left_res),
		.right_res (right_res),
		.full      (out_full),
		.frame_out (frame_out)
	);

	`STEQ_ASSERT_NEXT(a_busy_after_accept, accept, !frame_in.ready, "ready right after accept")
	`STEQ_ASSERT_NEXT(a_result_lands, out_load, frame_out.valid, "result not presented")
	`STEQ_ASSERT(a_tap_range, (state_q == ST_MAC) |-> (tap_q <= TAP_Y2), "tap out of range")
	`STEQ_ASSERT(a_band_range, (state_q != ST_IDLE) |-> (band_q <= BAND_HIGH), "band out of range")

endmodule

`default_nettype wire

// ===== rtl/steq_lane.sv =====
// ----------------------------------------------------------------------------
// Equalizer channel lane
// One multiplier and accumulator running the three sections of one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module steq_lane
	import steq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  lane_ctrl_t ctrl,
	input  sample_t    sample_in,
	input  coeff_t     coeff,
	output sample_t    result
);

	sample_t xh_q [NUM_BANDS][2];
	sample_t yh_q [NUM_BANDS][2];
	sample_t cur_x_q;
	sample_t operand;
	sample_t y_sat;

	logic signed [PROD_BITS-1:0] prod_s1;
	logic                        mac_s1;
	logic                        first_s1;
	logic                        sub_s1;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [ACC_BITS-1:0]  acc_base;
	logic signed [ACC_BITS-1:0]  prod_ext;
	logic signed [ACC_BITS-1:0]  shifted;

	always_comb begin
		case (ctrl.tap)
			TAP_X0:  operand = cur_x_q;
			TAP_X1:  operand = xh_q[ctrl.band][0];
			TAP_X2:  operand = xh_q[ctrl.band][1];
			TAP_Y1:  operand = yh_q[ctrl.band][0];
			TAP_Y2:  operand = yh_q[ctrl.band][1];
			default: operand = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coeff * operand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1   <= 1'b0;
			first_s1 <= 1'b0;
			sub_s1   <= 1'b0;
		end else begin
			mac_s1   <= ctrl.mac;
			first_s1 <= ctrl.first;
			sub_s1   <= ctrl.sub;
		end
	end

	assign acc_base = first_s1 ? ROUND_CONST : acc_q;
	assign prod_ext = ACC_BITS'(prod_s1);

	always_ff @(posedge clk) begin
		if (mac_s1) begin
			acc_q <= sub_s1 ? (acc_base - prod_ext) : (acc_base + prod_ext);
		end
	end

	always_comb begin
		shifted = acc_q >>> COEFF_FRAC_BITS;
		if (shifted > SAT_HI) begin
			y_sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (shifted < SAT_LO) begin
			y_sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			y_sat = shifted[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			for (int b = 0; b < NUM_BANDS; b++) begin
				xh_q[b][0] <= '0;
				xh_q[b][1] <= '0;
				yh_q[b][0] <= '0;
				yh_q[b][1] <= '0;
			end
		end else if (ctrl.load) begin
			cur_x_q <= sample_in;
		end else if (ctrl.wb) begin
			xh_q[ctrl.band][1] <= xh_q[ctrl.band][0];
			xh_q[ctrl.band][0] <= cur_x_q;
			yh_q[ctrl.band][1] <= yh_q[ctrl.band][0];
			yh_q[ctrl.band][0] <= y_sat;
			cur_x_q            <= y_sat;
		end
	end

	assign result = cur_x_q;

endmodule

`default_nettype wire

// ===== rtl/steq_merge.sv =====
// ----------------------------------------------------------------------------
// Equalizer output stage
// Joins both lane results into one output item register.
// ----------------------------------------------------------------------------
`default_nettype none

module steq_merge
	import steq_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  logic               load,
	input  sample_t            left_res,
	input  sample_t            right_res,
	output logic               full,
	steq_out_if.source         frame_out
);

	logic    valid_q;
	sample_t left_q;
	sample_t right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q  <= left_res;
			right_q <= right_res;
		end
	end

	assign full                = valid_q;
	assign frame_out.valid     = valid_q;
	assign frame_out.left_out  = left_q;
	assign frame_out.right_out = right_q;

endmodule

`default_nettype wire
